// ===== rtl/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Power button supervisor package
// Shared constants, register indexes, LED codes and the control and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int TIME_BITS_DEFAULT = 48;
  localparam int NOW_W             = 48;
  localparam int CFG_DATA_W        = 28;
  localparam int CFG_INDEX_W       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOGGLE_HOLDOFF = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT   = 3'd5;

  localparam logic [15:0] GAIN_RESET     = 16'd22323;
  localparam logic [11:0] OFFSET_RESET   = 12'd232;
  localparam logic [20:0] ALPHA_RESET    = 21'd524;
  localparam logic [23:0] HOLDOFF_RESET  = 24'd1000000;
  localparam logic [23:0] LONG_PRESS_RESET = 24'd1000000;
  localparam logic [27:0] TIMEOUT_RESET  = 28'd30000000;

  localparam logic [20:0] Q20_ONE = 21'h100000;

  localparam logic [1:0] LED_NONE   = 2'd0;
  localparam logic [1:0] LED_GREEN  = 2'd1;
  localparam logic [1:0] LED_YELLOW = 2'd2;
  localparam logic [1:0] LED_RED    = 2'd3;

  typedef struct packed {
    logic load;
    logic scale;
    logic filt;
    logic smooth;
    logic emit;
  } pbs_cmd_t;

  typedef struct packed {
    logic out_free;
  } pbs_status_t;

endpackage

// ===== rtl/pbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Power button supervisor controller
// Sequences one word through load, scaling, filter products, smoothing and
// the hand-over into the output register.
// ----------------------------------------------------------------------------
module pbs_ctrl import pbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pbs_status_t status,
  output pbs_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCALE  = 3'd1;
  localparam logic [2:0] ST_FILT   = 3'd2;
  localparam logic [2:0] ST_SMOOTH = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_FILT;
      end
      ST_FILT: begin
        cmd.filt   = 1'b1;
        state_next = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/pbs_datapath.sv =====
// ----------------------------------------------------------------------------
// Power button supervisor datapath
// Configuration registers, supervisor state, battery scaling and smoothing
// arithmetic, and the output register.
// ----------------------------------------------------------------------------
module pbs_datapath import pbs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [NOW_W-1:0]       now_us,
  input  logic                   button_level,
  input  logic [11:0]            battery_mv,
  input  logic                   message_seen,
  input  logic                   set_active,
  input  logic                   off_request,
  input  logic [31:0]            off_delay_us,
  input  pbs_cmd_t               cmd,
  output pbs_status_t            status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   motor_enable,
  output logic                   link_active,
  output logic [1:0]             led_command,
  output logic                   power_kill,
  output logic [15:0]            pack_voltage_mv
);

  localparam int PROD_W = 53;

  logic [15:0] divider_gain_q12;
  logic [11:0] divider_offset_mv;
  logic [20:0] filter_alpha_q20;
  logic [23:0] toggle_holdoff_us;
  logic [23:0] long_press_us;
  logic [27:0] link_timeout_us;

  logic                 pressed_before;
  logic [TIME_BITS-1:0] press_start_time;
  logic [TIME_BITS-1:0] last_toggle_time;
  logic [TIME_BITS-1:0] last_message_time;
  logic                 active_flag;
  logic                 motor_on;
  logic [31:0]          smoothed_voltage_q16;
  logic                 first_tick_done;
  logic [TIME_BITS-1:0] off_deadline;
  logic                 off_pending;
  logic                 killed;

  logic [TIME_BITS-1:0] now_q;
  logic                 seed_q;
  logic [1:0]           led_q;
  logic [27:0]          prod_mg;
  logic [31:0]          scaled;
  logic [PROD_W-1:0]    prod_new;
  logic [PROD_W-1:0]    prod_old;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] toggle_ref;
  logic [TIME_BITS-1:0] message_ref;
  logic [TIME_BITS-1:0] message_age;
  logic [TIME_BITS-1:0] toggle_age;
  logic [TIME_BITS-1:0] held;
  logic                 released;
  logic                 toggle;
  logic                 long_press;
  logic                 active_next;
  logic [32:0]          scaled_sum;
  logic [20:0]          alpha_sat;
  logic [PROD_W-1:0]    filt_sum;
  logic [32:0]          round_sum;
  logic [15:0]          vout;

  always_comb begin
    now_t       = TIME_BITS'(now_us);
    toggle_ref  = first_tick_done ? last_toggle_time : now_t;
    message_ref = message_seen ? now_t : last_message_time;
    message_age = now_t - message_ref;
    active_next = (active_flag | set_active) &&
                  !(message_age > TIME_BITS'(link_timeout_us));
    held        = '0;
    released    = 1'b0;
    if (button_level) begin
      if (pressed_before) begin
        held = now_t - press_start_time;
      end
    end else begin
      released = pressed_before;
    end
    toggle_age = now_t - toggle_ref;
    toggle     = released && (toggle_age > TIME_BITS'(toggle_holdoff_us));
    long_press = held > TIME_BITS'(long_press_us);

    scaled_sum = {1'b0, prod_mg, 4'b0000} + {5'b00000, divider_offset_mv, 16'h0000};
    alpha_sat  = (filter_alpha_q20 > Q20_ONE) ? Q20_ONE : filter_alpha_q20;
    filt_sum   = prod_new + prod_old + PROD_W'(Q20_ONE >> 1);
    round_sum  = {1'b0, smoothed_voltage_q16} + 33'h0_0000_8000;
    vout       = round_sum[32] ? 16'hFFFF : round_sum[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_gain_q12  <= GAIN_RESET;
      divider_offset_mv <= OFFSET_RESET;
      filter_alpha_q20  <= ALPHA_RESET;
      toggle_holdoff_us <= HOLDOFF_RESET;
      long_press_us     <= LONG_PRESS_RESET;
      link_timeout_us   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIVIDER_GAIN:   divider_gain_q12  <= cfg_data[15:0];
        REG_DIVIDER_OFFSET: divider_offset_mv <= cfg_data[11:0];
        REG_FILTER_ALPHA:   filter_alpha_q20  <= cfg_data[20:0];
        REG_TOGGLE_HOLDOFF: toggle_holdoff_us <= cfg_data[23:0];
        REG_LONG_PRESS:     long_press_us     <= cfg_data[23:0];
        REG_LINK_TIMEOUT:   link_timeout_us   <= cfg_data[27:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_before    <= 1'b0;
      press_start_time  <= '0;
      last_toggle_time  <= '0;
      last_message_time <= '0;
      active_flag       <= 1'b0;
      motor_on          <= 1'b0;
      first_tick_done   <= 1'b0;
      off_deadline      <= '0;
      off_pending       <= 1'b0;
      killed            <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cmd.load) begin
        first_tick_done   <= 1'b1;
        last_message_time <= message_ref;
        active_flag       <= active_next;
        if (off_request) begin
          off_deadline <= now_t + TIME_BITS'(off_delay_us);
          off_pending  <= 1'b1;
        end
        pressed_before <= button_level;
        if (button_level && !pressed_before) begin
          press_start_time <= now_t;
        end
        if (toggle) begin
          motor_on         <= !motor_on;
          last_toggle_time <= now_t;
        end else begin
          last_toggle_time <= toggle_ref;
        end
        if (long_press) begin
          killed <= 1'b1;
        end
      end
      if (cmd.scale && off_pending && (now_q > off_deadline)) begin
        killed <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_q   <= now_t;
      seed_q  <= !first_tick_done;
      prod_mg <= 28'(battery_mv) * 28'(divider_gain_q12);
      if (long_press) begin
        led_q <= LED_RED;
      end else if (toggle) begin
        led_q <= motor_on ? LED_YELLOW : LED_GREEN;
      end else begin
        led_q <= LED_NONE;
      end
    end
    if (cmd.scale) begin
      scaled <= scaled_sum[32] ? 32'hFFFF_FFFF : scaled_sum[31:0];
    end
    if (cmd.filt) begin
      prod_new <= PROD_W'(scaled) * PROD_W'(alpha_sat);
      prod_old <= PROD_W'(smoothed_voltage_q16) * PROD_W'(Q20_ONE - alpha_sat);
    end
    if (cmd.smooth) begin
      smoothed_voltage_q16 <= seed_q ? scaled : filt_sum[51:20];
    end
    if (cmd.emit) begin
      motor_enable    <= motor_on;
      link_active     <= active_flag;
      led_command     <= led_q;
      power_kill      <= killed;
      pack_voltage_mv <= vout;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/power_button_supervisor_unit.sv =====
// ----------------------------------------------------------------------------
// Power button supervisor
// Tick-driven supervisor for button, host link, scheduled power-off and the
// smoothed battery pack voltage.
// ----------------------------------------------------------------------------
// Usage: each input word is one supervisor tick (time, button level, battery
// reading and host event flags) and yields exactly one output word with the
// motor enable, link-active flag, LED command, sticky power kill and the
// smoothed pack voltage. Both channels use valid and ready.
// A tick runs through these steps from acceptance to the output register:
// the acceptance cycle updates the timing state and forms the battery product,
// followed by offset scaling, the two filter products, the smoothing sum and
// the load of the output register. A new word is accepted only once the
// previous one has been loaded into the output register.
// The output register frees the input side: a new word is accepted while the
// previous result waits. If the receiver stalls longer, the word in flight
// holds in its last step until the output register is free.
// Reset restores the register defaults and clears all supervisor state; the
// first tick after reset seeds the toggle time and the voltage filter.
// Configuration writes take effect at once; the user is to make them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module power_button_supervisor_unit import pbs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NOW_W-1:0]       now_us,
  input  logic                   button_level,
  input  logic [11:0]            battery_mv,
  input  logic                   message_seen,
  input  logic                   set_active,
  input  logic                   off_request,
  input  logic [31:0]            off_delay_us,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   motor_enable,
  output logic                   link_active,
  output logic [1:0]             led_command,
  output logic                   power_kill,
  output logic [15:0]            pack_voltage_mv
);

  pbs_cmd_t    cmd;
  pbs_status_t status;

  pbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pbs_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .now_us          (now_us),
    .button_level    (button_level),
    .battery_mv      (battery_mv),
    .message_seen    (message_seen),
    .set_active      (set_active),
    .off_request     (off_request),
    .off_delay_us    (off_delay_us),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .motor_enable    (motor_enable),
    .link_active     (link_active),
    .led_command     (led_command),
    .power_kill      (power_kill),
    .pack_voltage_mv (pack_voltage_mv)
  );

endmodule

// ===== rtl/pbs_checker.sv =====
// ----------------------------------------------------------------------------
// Power button supervisor checker
// Port-level properties of the supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module pbs_checker import pbs_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] led_command,
  input logic       power_kill,
  input logic [15:0] pack_voltage_mv
);

  // A word is worked on alone, so the input closes right after acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word was in progress");

  // A red LED request always comes with the power kill.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (led_command == LED_RED) |-> power_kill)
    else $error("red LED without power kill");

  // Once shown, the power kill never drops.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && power_kill |=> power_kill)
    else $error("power kill dropped");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pack_voltage_mv))
    else $error("stalled output word changed");

endmodule

bind power_button_supervisor_unit pbs_checker u_pbs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .led_command     (led_command),
  .power_kill      (power_kill),
  .pack_voltage_mv (pack_voltage_mv)
);
